// File: rtl/drg_pkg.sv
// ----------------------------------------------------------------------------
// drg_pkg
// Shared types, constants and register codes of the depth-to-color
// registration block.
// ----------------------------------------------------------------------------
package drg_pkg;

  // image size defaults
  localparam int IMG_WIDTH_DEF  = 1280;
  localparam int IMG_HEIGHT_DEF = 800;

  // no-depth marker of the aligned store
  localparam logic [15:0] NO_DEPTH = 16'hFFFF;

  // datapath widths
  localparam int C_W   = 49;  // camera-frame coordinate, scale 2^22, signed
  localparam int N_W   = 66;  // c * f product, signed
  localparam int NUM_W = 64;  // dividend magnitude
  localparam int DEN_W = 49;  // divisor magnitude
  localparam int Q_W   = 65;  // signed quotient
  localparam int S_W   = 66;  // rounded pixel position, Q.4, signed

  // configuration register reset values
  localparam logic [63:0] ROW_X_RST = 64'd16384;
  localparam logic [63:0] ROW_Y_RST = 64'd1073741824;
  localparam logic [63:0] ROW_Z_RST = 64'd70368744177664;
  localparam logic [63:0] DINT_RST  = 64'd0;
  localparam logic [63:0] CINT_RST  = 64'd0;

  // item commands
  localparam logic CMD_PROJECT = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  // configuration register index
  typedef enum logic [2:0] {
    CFG_ROW_X = 3'd0,
    CFG_ROW_Y = 3'd1,
    CFG_ROW_Z = 3'd2,
    CFG_DINT  = 3'd3,
    CFG_CINT  = 3'd4
  } cfg_idx_t;

  // item fields carried along the pipeline
  typedef struct packed {
    logic        cmd;
    logic [10:0] col;
    logic [9:0]  row;
    logic [15:0] depth;
  } tag_t;

  // store access request
  typedef struct packed {
    logic valid;
    logic is_read;
    logic hit;
  } req_t;

endpackage

// File: rtl/drg_div.sv
// ----------------------------------------------------------------------------
// drg_div
// Pipelined restoring divider, one quotient bit per stage, two dividends
// over one shared divisor, quotients truncated toward zero.
// ----------------------------------------------------------------------------
module drg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  drg_pkg::tag_t               in_tag,
  input  logic                        in_live,
  input  logic signed [drg_pkg::N_W-1:0] num_x,
  input  logic signed [drg_pkg::N_W-1:0] num_y,
  input  logic signed [drg_pkg::C_W-1:0] den,
  output logic                        out_vld,
  output drg_pkg::tag_t               out_tag,
  output logic                        out_live,
  output logic signed [drg_pkg::Q_W-1:0] q_x,
  output logic signed [drg_pkg::Q_W-1:0] q_y
);
  import drg_pkg::*;

  localparam int ST = NUM_W + 1;

  logic                 vld_r  [0:NUM_W];
  tag_t                 tag_r  [0:NUM_W];
  logic                 live_r [0:NUM_W];
  logic                 negx_r [0:NUM_W];
  logic                 negy_r [0:NUM_W];
  logic [DEN_W-1:0]     d_r    [0:NUM_W];
  logic [DEN_W-1:0]     rx_r   [0:NUM_W];
  logic [DEN_W-1:0]     ry_r   [0:NUM_W];
  logic [NUM_W-1:0]     nqx_r  [0:NUM_W];
  logic [NUM_W-1:0]     nqy_r  [0:NUM_W];

  logic                 ovld_r;
  tag_t                 otag_r;
  logic                 olive_r;
  logic signed [Q_W-1:0] qx_r;
  logic signed [Q_W-1:0] qy_r;

  logic [N_W-1:0]       absx;
  logic [N_W-1:0]       absy;
  logic [C_W-1:0]       absd;

  // one restoring step: remainder in the top bits, dividend/quotient below
  function automatic logic [DEN_W+NUM_W-1:0] div_step(
    input logic [DEN_W-1:0] rem,
    input logic [NUM_W-1:0] nq,
    input logic [DEN_W-1:0] d
  );
    logic [DEN_W:0]   t;
    logic [DEN_W:0]   diff;
    logic [NUM_W-1:0] nq_s;
    t    = {rem, nq[NUM_W-1]};
    diff = t - {1'b0, d};
    nq_s = {nq[NUM_W-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      div_step = {diff[DEN_W-1:0], nq_s[NUM_W-1:1], 1'b1};
    end else begin
      div_step = {t[DEN_W-1:0], nq_s};
    end
  endfunction

  // magnitudes of the operands
  assign absx = num_x[N_W-1] ? N_W'(-num_x) : num_x;
  assign absy = num_y[N_W-1] ? N_W'(-num_y) : num_y;
  assign absd = den[C_W-1] ? C_W'(-den) : den;

  // entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0]  <= in_tag;
      live_r[0] <= in_live;
      negx_r[0] <= num_x[N_W-1] ^ den[C_W-1];
      negy_r[0] <= num_y[N_W-1] ^ den[C_W-1];
      d_r[0]    <= DEN_W'(absd);
      rx_r[0]   <= '0;
      ry_r[0]   <= '0;
      nqx_r[0]  <= absx[NUM_W-1:0];
      nqy_r[0]  <= absy[NUM_W-1:0];
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < NUM_W; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[i+1]  <= tag_r[i];
        live_r[i+1] <= live_r[i];
        negx_r[i+1] <= negx_r[i];
        negy_r[i+1] <= negy_r[i];
        d_r[i+1]    <= d_r[i];
        {rx_r[i+1], nqx_r[i+1]} <= div_step(rx_r[i], nqx_r[i], d_r[i]);
        {ry_r[i+1], nqy_r[i+1]} <= div_step(ry_r[i], nqy_r[i], d_r[i]);
      end
    end
  end

  // sign of the quotients
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= vld_r[ST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      otag_r  <= tag_r[ST-1];
      olive_r <= live_r[ST-1];
      qx_r    <= negx_r[ST-1] ? -$signed({1'b0, nqx_r[ST-1]})
                              :  $signed({1'b0, nqx_r[ST-1]});
      qy_r    <= negy_r[ST-1] ? -$signed({1'b0, nqy_r[ST-1]})
                              :  $signed({1'b0, nqy_r[ST-1]});
    end
  end

  assign out_vld  = ovld_r;
  assign out_tag  = otag_r;
  assign out_live = olive_r;
  assign q_x      = qx_r;
  assign q_y      = qy_r;

endmodule

// File: rtl/drg_proj.sv
// ----------------------------------------------------------------------------
// drg_proj
// Projection pipeline: back-projection, rigid transform, perspective divide,
// color projection and store address forming for every item.
// ----------------------------------------------------------------------------
module drg_proj #(
  parameter int IMG_WIDTH  = drg_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = drg_pkg::IMG_HEIGHT_DEF,
  parameter int AW         = $clog2(IMG_WIDTH * IMG_HEIGHT)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 take,
  input  drg_pkg::tag_t        in_tag,
  input  logic [63:0]          row_x,
  input  logic [63:0]          row_y,
  input  logic [63:0]          row_z,
  input  logic [63:0]          dint,
  input  logic [63:0]          cint,
  output drg_pkg::req_t        req,
  output logic [AW-1:0]        req_addr,
  output logic [15:0]          req_data
);
  import drg_pkg::*;

  localparam int X_W = $clog2(IMG_WIDTH);
  localparam int Y_W = $clog2(IMG_HEIGHT);
  localparam logic signed [S_W-1:0] X_LIM  = S_W'(IMG_WIDTH * 16);
  localparam logic signed [S_W-1:0] Y_LIM  = S_W'(IMG_HEIGHT * 16);
  localparam logic signed [S_W-1:0] LO_LIM = S_W'(-16);

  logic        v_r   [1:6];
  tag_t        tag_r [1:6];

  logic signed [33:0]  ux_r, uy_r;
  logic signed [50:0]  mx_r, my_r;
  logic signed [46:0]  pr_r [0:2][0:2];
  logic signed [C_W-1:0] c_r [0:2];
  logic signed [C_W-1:0] c_nxt [0:2];
  logic        live4_r, live5_r, live6_r;
  logic [39:0]         lox_r, loy_r;
  logic signed [41:0]  hix_r, hiy_r;
  logic signed [C_W-1:0] cz5_r, cz6_r;
  logic signed [N_W-1:0] nx_r, ny_r;

  logic signed [16:0]  ex, ey;
  logic signed [30:0]  dx, dy;
  logic signed [24:0]  dz;
  logic [63:0]         rows [0:2];

  logic                dv_vld;
  tag_t                dv_tag;
  logic                dv_live;
  logic signed [Q_W-1:0] qx, qy;

  logic                b1_v_r;
  tag_t                b1_tag_r;
  logic                b1_live_r;
  logic signed [S_W-1:0] sx_r, sy_r;

  logic                in_x, in_y;
  logic [X_W-1:0]      px, xsel;
  logic [Y_W-1:0]      py, ysel;
  logic                rd_hit;
  req_t                req_r, req_nxt;
  logic [AW-1:0]       addr_r;
  logic [15:0]         data_r;

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 6; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[1] <= take;
      for (int i = 2; i <= 6; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[1] <= in_tag;
      for (int i = 2; i <= 6; i++) tag_r[i] <= tag_r[i-1];
    end
  end

  // ray through the depth pixel, scale 2^28
  assign ex = $signed({2'b0, in_tag.col, 4'b0}) - $signed({1'b0, dint[47:32]});
  assign ey = $signed({3'b0, in_tag.row, 4'b0}) - $signed({1'b0, dint[63:48]});

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r <= 34'(ex) * 34'($signed({1'b0, dint[15:0]}));
      uy_r <= 34'(ey) * 34'($signed({1'b0, dint[31:16]}));
    end
  end

  // scale the ray by depth
  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= 51'(ux_r) * 51'($signed({1'b0, tag_r[1].depth}));
      my_r <= 51'(uy_r) * 51'($signed({1'b0, tag_r[1].depth}));
    end
  end

  // rotation products, scale 2^22
  assign dx = mx_r[50:20];
  assign dy = my_r[50:20];
  assign dz = $signed({1'b0, tag_r[2].depth, 8'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pr_r[k][0] <= 47'($signed(rows[k][15:0]))  * 47'(dx);
        pr_r[k][1] <= 47'($signed(rows[k][31:16])) * 47'(dy);
        pr_r[k][2] <= 47'($signed(rows[k][47:32])) * 47'(dz);
      end
    end
  end

  // sum of products plus translation
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_nxt[k] = C_W'(pr_r[k][0]) + C_W'(pr_r[k][1]) + C_W'(pr_r[k][2])
               + $signed({{(C_W-38){rows[k][63]}}, rows[k][63:48], 22'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) c_r[k] <= c_nxt[k];
      live4_r <= (tag_r[3].cmd == CMD_PROJECT) && (tag_r[3].depth != 16'd0)
              && (c_nxt[2] != '0);
    end
  end

  // c * f as two partial products
  always_ff @(posedge clk) begin
    if (en) begin
      lox_r   <= 40'(c_r[0][23:0]) * 40'(cint[15:0]);
      loy_r   <= 40'(c_r[1][23:0]) * 40'(cint[31:16]);
      hix_r   <= 42'($signed(c_r[0][C_W-1:24])) * 42'($signed({1'b0, cint[15:0]}));
      hiy_r   <= 42'($signed(c_r[1][C_W-1:24])) * 42'($signed({1'b0, cint[31:16]}));
      cz5_r   <= c_r[2];
      live5_r <= live4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r    <= $signed({hix_r, 24'b0}) + $signed({26'b0, lox_r});
      ny_r    <= $signed({hiy_r, 24'b0}) + $signed({26'b0, loy_r});
      cz6_r   <= cz5_r;
      live6_r <= live5_r;
    end
  end

  // perspective divide
  drg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v_r[6]),
    .in_tag   (tag_r[6]),
    .in_live  (live6_r),
    .num_x    (nx_r),
    .num_y    (ny_r),
    .den      (cz6_r),
    .out_vld  (dv_vld),
    .out_tag  (dv_tag),
    .out_live (dv_live),
    .q_x      (qx),
    .q_y      (qy)
  );

  // add principal point and rounding half
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_tag_r  <= dv_tag;
      b1_live_r <= dv_live;
      sx_r <= S_W'(qx) + $signed({{(S_W-16){1'b0}}, cint[47:32]}) + S_W'(8);
      sy_r <= S_W'(qy) + $signed({{(S_W-16){1'b0}}, cint[63:48]}) + S_W'(8);
    end
  end

  // frame test, truncation toward zero maps -15..-1 to pixel 0
  assign in_x = (sx_r > LO_LIM) && (sx_r < X_LIM);
  assign in_y = (sy_r > LO_LIM) && (sy_r < Y_LIM);
  assign px   = sx_r[S_W-1] ? '0 : sx_r[X_W+3:4];
  assign py   = sy_r[S_W-1] ? '0 : sy_r[Y_W+3:4];
  assign rd_hit = ({21'b0, b1_tag_r.col} < 32'(IMG_WIDTH))
               && ({22'b0, b1_tag_r.row} < 32'(IMG_HEIGHT));

  always_comb begin
    req_nxt.valid   = b1_v_r;
    req_nxt.is_read = (b1_tag_r.cmd == CMD_READ);
    if (b1_tag_r.cmd == CMD_READ) begin
      req_nxt.hit = rd_hit;
      xsel        = X_W'(b1_tag_r.col);
      ysel        = Y_W'(b1_tag_r.row);
    end else begin
      req_nxt.hit = b1_live_r && in_x && in_y;
      xsel        = px;
      ysel        = py;
    end
  end

  // store address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= '0;
    end else if (en) begin
      req_r <= req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      addr_r <= AW'(32'(ysel) * 32'(IMG_WIDTH) + 32'(xsel));
      data_r <= b1_tag_r.depth;
    end
  end

  assign req      = req_r;
  assign req_addr = addr_r;
  assign req_data = data_r;

endmodule

// File: rtl/drg_store.sv
// ----------------------------------------------------------------------------
// drg_store
// Aligned depth store with clearing pass after reset, read-and-clear port,
// and a two-item output queue that sets the pipeline enable.
// ----------------------------------------------------------------------------
module drg_store #(
  parameter int IMG_WIDTH  = drg_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = drg_pkg::IMG_HEIGHT_DEF,
  parameter int AW         = $clog2(IMG_WIDTH * IMG_HEIGHT)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  drg_pkg::req_t  req,
  input  logic [AW-1:0]  req_addr,
  input  logic [15:0]    req_data,
  output logic           en,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [15:0]    out_depth
);
  import drg_pkg::*;

  localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;

  logic [15:0]   mem [0:DEPTH-1];
  logic          clearing_r;
  logic [AW-1:0] clr_cnt_r;
  logic [15:0]   rd_data_r;
  logic          rd_pend_r;
  logic          rd_hit_r;
  logic [15:0]   q_r [0:1];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;

  logic          we, re, pop, push;
  logic [AW-1:0] wa;
  logic [15:0]   wd;
  logic [2:0]    load;

  // clearing pass over every entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(DEPTH - 1)) clearing_r <= 1'b0;
    end
  end

  // store access
  assign re = en && req.valid && req.is_read && req.hit;
  assign we = clearing_r || (en && req.valid && req.hit);
  assign wa = clearing_r ? clr_cnt_r : req_addr;
  assign wd = (clearing_r || req.is_read) ? NO_DEPTH : req_data;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_data_r <= mem[req_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      rd_hit_r  <= 1'b0;
    end else begin
      rd_pend_r <= en && req.valid && req.is_read;
      rd_hit_r  <= re;
    end
  end

  // output queue
  assign push = rd_pend_r;
  assign pop  = (cnt_r != 2'd0) && !out_stall;
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= rd_hit_r ? rd_data_r : NO_DEPTH;
  end

  // advance only while a read issued now still finds room
  assign load = {1'b0, cnt_r} + {2'b0, rd_pend_r} - {2'b0, pop};
  assign en   = !clearing_r && (load < 3'd2);

  assign out_valid = (cnt_r != 2'd0);
  assign out_depth = q_r[rp_r];

  // queue never holds more than two items
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output queue count out of range");

  // a returning read always finds room
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == 2'd2))
    else $error("output queue overflow");

  // nothing reaches the store during the clearing pass
  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !req.valid && !rd_pend_r)
    else $error("store access during clearing pass");

  // a read result is pushed into the queue in the cycle after the read
  a_rd_push: assert property (@(posedge clk) disable iff (!rst_n)
    (en && req.valid && req.is_read) |=> push)
    else $error("read result lost");

endmodule

// File: rtl/depth_to_color_registration.sv
// A read item passes the projection stages, the divider, the rounding stage,
// the request register and the store read into the output queue.
// Throughput: one item per cycle while in_stall is low; the store has one
// write and one read access per cycle, used at the end of the pipeline,
// where a read item reads and clears its entry. Reset: synchronous; after
// reset a clearing pass writes 0xFFFF to all entries, one per cycle.
// ----------------------------------------------------------------------------
// depth_to_color_registration_core
// Reprojects depth samples into the color camera's pixel grid and returns
// and clears aligned store entries on read items.
// ----------------------------------------------------------------------------
module depth_to_color_registration_core #(
  parameter int IMG_WIDTH  = drg_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = drg_pkg::IMG_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [10:0] in_col,
  input  logic [9:0]  in_row,
  input  logic [15:0] in_depth_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_depth,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import drg_pkg::*;

  localparam int AW = $clog2(IMG_WIDTH * IMG_HEIGHT);

  logic [63:0]   row_x_r, row_y_r, row_z_r, dint_r, cint_r;
  logic          en;
  logic          take;
  tag_t          in_tag;
  req_t          req;
  logic [AW-1:0] req_addr;
  logic [15:0]   req_data;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r <= ROW_X_RST;
      row_y_r <= ROW_Y_RST;
      row_z_r <= ROW_Z_RST;
      dint_r  <= DINT_RST;
      cint_r  <= CINT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROW_X: row_x_r <= cfg_data;
        CFG_ROW_Y: row_y_r <= cfg_data;
        CFG_ROW_Z: row_z_r <= cfg_data;
        CFG_DINT:  dint_r  <= cfg_data;
        CFG_CINT:  cint_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input handshake, stalled in the clearing pass and with a full output queue
  assign in_stall = !en;
  assign take     = in_valid && !in_stall;

  assign in_tag.cmd   = in_cmd;
  assign in_tag.col   = in_col;
  assign in_tag.row   = in_row;
  assign in_tag.depth = in_depth_value;

  drg_proj #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT),
    .AW         (AW)
  ) u_proj (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .take     (take),
    .in_tag   (in_tag),
    .row_x    (row_x_r),
    .row_y    (row_y_r),
    .row_z    (row_z_r),
    .dint     (dint_r),
    .cint     (cint_r),
    .req      (req),
    .req_addr (req_addr),
    .req_data (req_data)
  );

  drg_store #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT),
    .AW         (AW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_addr  (req_addr),
    .req_data  (req_data),
    .en        (en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_depth (out_depth)
  );

endmodule
